### src/idle_flow_leak_detector_macros.svh
// assertion macros for the idle flow leak detector
// used by the top level only, no other dependencies
`ifndef IDLE_FLOW_LEAK_DETECTOR_MACROS_SVH
`define IDLE_FLOW_LEAK_DETECTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define IFLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IFLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ifld_pkg.sv
// shared types and constants for the idle flow leak detector
// no dependencies
package ifld_pkg;

    localparam int MAX_ROADS     = 2;
    localparam int NUM_ROADS_DEF = 2;
    localparam int WIN_W         = 26;  // 65535 s * 1000 fits in 26 bits
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [31:0]      SETTLE_MS   = 32'd3000;
    localparam logic [WIN_W-1:0] MS_PER_SEC  = WIN_W'(1000);
    localparam logic [WIN_W-1:0] WIN_MS_RST  = WIN_W'(60000);
    localparam logic [15:0]      THRESH_RST  = 16'd10;
    localparam logic [1:0]       ENABLE_RST  = 2'b11;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SEC      = 2'd0,
        REG_PULSE_THRESHOLD = 2'd1,
        REG_ROAD_ENABLE     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [WIN_W-1:0] win_ms;
        logic [15:0]      threshold;
        logic [1:0]       enable;
    } cfg_t;

    typedef struct packed {
        logic step;     // item leaves the input register this cycle
        logic clear;
        logic settled;  // monitoring allowed and past settle time
        logic enable;
    } road_ctl_t;

    typedef struct packed {
        logic        alert;  // sticky alert after this item
        logic        first;
        logic        hit;
        logic [31:0] delta;
    } road_res_t;

endpackage

### src/idle_flow_leak_detector.sv
// idle leak detector for two flow-metered water roads, top level
// depends on ifld_pkg, ifld_cfg, ifld_road and idle_flow_leak_detector_macros.svh
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, now_ms, monitor_ok, pulses_road_*
// out      output     out_valid / out_stall alert_mask .. cleared, one word per input
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word accepted every cycle while in_stall is low; a result goes through the
// input register, then the result register fed by the lane logic
// reset loads the register defaults and clears alerts, windows and settle state
// a stalled result holds the input register; in_stall rises only when both are full
// cfg_ready is always high, writes land in the next cycle
module idle_flow_leak_detector
    import ifld_pkg::*;
#(
    parameter int NUM_ROADS = NUM_ROADS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [31:0]           now_ms,
    input  logic                  monitor_ok,
    input  logic [31:0]           pulses_road_one,
    input  logic [31:0]           pulses_road_two,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            alert_mask,
    output logic                  any_alert,
    output logic                  shutoff_request,
    output logic [1:0]            first_alert_mask,
    output logic [31:0]           leak_delta_one,
    output logic [31:0]           leak_delta_two,
    output logic                  cleared,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "idle_flow_leak_detector_macros.svh"

    cfg_t cfg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_mode_reg;
    logic [31:0] s1_now_reg;
    logic        s1_ok_reg;
    logic [31:0] s1_p1_reg;
    logic [31:0] s1_p2_reg;

    // settle tracking
    logic        allowed_before_reg, allowed_before_next;
    logic [31:0] allowed_since_reg, allowed_since_next;
    logic        settled;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  alert_reg;
    logic        any_reg;
    logic        shutoff_reg;
    logic [1:0]  first_reg;
    logic [31:0] delta_one_reg;
    logic [31:0] delta_two_reg;
    logic        cleared_reg;

    logic        accept;
    logic        adv;
    logic        is_clear;

    logic [31:0] counts [MAX_ROADS];
    road_res_t   res    [MAX_ROADS];
    road_ctl_t   ctl    [MAX_ROADS];

    ifld_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: input register moves on whenever the result slot is free
    assign adv      = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;
    assign is_clear = (s1_mode_reg == MODE_CLEAR);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // settled only when allowed on the previous tick too and 3 s have passed;
    // a fresh allow restarts the settle timer at this tick
    assign settled = s1_ok_reg && allowed_before_reg &&
                     ((s1_now_reg - allowed_since_reg) >= SETTLE_MS);

    always_comb
    begin
        allowed_before_next = allowed_before_reg;
        allowed_since_next  = allowed_since_reg;
        if (!is_clear && (s1_ok_reg != allowed_before_reg))
        begin
            allowed_before_next = s1_ok_reg;
            allowed_since_next  = s1_ok_reg ? s1_now_reg : 32'd0;
        end
    end

    assign counts[0] = s1_p1_reg;
    assign counts[1] = s1_p2_reg;

    // road lanes side by side; lanes past NUM_ROADS are never monitored
    for (genvar r = 0; r < MAX_ROADS; r++)
    begin : g_road
        if (r < NUM_ROADS)
        begin : g_on
            always_comb
            begin
                ctl[r].step    = adv;
                ctl[r].clear   = is_clear;
                ctl[r].settled = settled;
                ctl[r].enable  = cfg.enable[r];
            end

            ifld_road u_road
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[r]),
                .now_ms    (s1_now_reg),
                .count     (counts[r]),
                .win_ms    (cfg.win_ms),
                .threshold (cfg.threshold),
                .res       (res[r])
            );
        end
        else
        begin : g_off
            assign ctl[r] = '0;
            assign res[r] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            allowed_before_reg <= 1'b0;
            allowed_since_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                allowed_before_reg <= allowed_before_next;
                allowed_since_reg  <= allowed_since_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= mode;
            s1_now_reg  <= now_ms;
            s1_ok_reg   <= monitor_ok;
            s1_p1_reg   <= pulses_road_one;
            s1_p2_reg   <= pulses_road_two;
        end
        if (adv)
        begin
            alert_reg     <= {res[1].alert, res[0].alert};
            any_reg       <= res[1].alert || res[0].alert;
            shutoff_reg   <= res[1].hit || res[0].hit;
            first_reg     <= {res[1].first, res[0].first};
            delta_one_reg <= res[0].delta;
            delta_two_reg <= res[1].delta;
            cleared_reg   <= is_clear;
        end
    end

    assign out_valid        = out_valid_reg;
    assign alert_mask       = alert_reg;
    assign any_alert        = any_reg;
    assign shutoff_request  = shutoff_reg;
    assign first_alert_mask = first_reg;
    assign leak_delta_one   = delta_one_reg;
    assign leak_delta_two   = delta_two_reg;
    assign cleared          = cleared_reg;

    // checks
    `IFLD_ASSERT_IMP(a_first_in_alert, clk, rst_n, out_valid_reg, (first_reg & ~alert_reg) == 2'b00, "first alert bit without sticky alert")
    `IFLD_ASSERT_IMP(a_first_shutoff, clk, rst_n, out_valid_reg && (first_reg != 2'b00), shutoff_reg, "first alert without shutoff request")
    `IFLD_ASSERT_IMP(a_shutoff_alert, clk, rst_n, out_valid_reg && shutoff_reg, any_reg, "shutoff request with no alert")
    `IFLD_ASSERT_IMP(a_clear_quiet, clk, rst_n, out_valid_reg && cleared_reg, (alert_reg == 2'b00) && !shutoff_reg, "clear left an alert or shutoff")
    `IFLD_ASSERT_NXT(a_adv_result, clk, rst_n, adv, out_valid_reg, "advanced word produced no result")

endmodule

### src/ifld_cfg.sv
// configuration registers, window length kept in milliseconds
// depends on ifld_pkg
module ifld_cfg
    import ifld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SEC:
                    cfg_next.win_ms = WIN_W'(cfg_data) * MS_PER_SEC;
                REG_PULSE_THRESHOLD:
                    cfg_next.threshold = cfg_data;
                REG_ROAD_ENABLE:
                    cfg_next.enable = cfg_data[1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_ms    <= WIN_MS_RST;
            cfg_reg.threshold <= THRESH_RST;
            cfg_reg.enable    <= ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/ifld_road.sv
// one road lane: window start state, sticky alert and threshold check
// depends on ifld_pkg
module ifld_road
    import ifld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  road_ctl_t        ctl,
    input  logic [31:0]      now_ms,
    input  logic [31:0]      count,
    input  logic [WIN_W-1:0] win_ms,
    input  logic [15:0]      threshold,
    output road_res_t        res
);

    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] start_count_reg, start_count_next;
    logic        alert_reg, alert_next;
    logic [31:0] elapsed;
    logic [31:0] delta;
    logic        closed;

    assign elapsed = now_ms - start_time_reg;
    assign delta   = count - start_count_reg;
    assign closed  = elapsed >= {{(32 - WIN_W){1'b0}}, win_ms};

    always_comb
    begin
        start_time_next  = start_time_reg;
        start_count_next = start_count_reg;
        alert_next       = alert_reg;
        res              = '0;
        if (ctl.clear)
        begin
            alert_next       = 1'b0;
            start_time_next  = now_ms;
            start_count_next = count;
        end
        else if (!ctl.settled || !ctl.enable)
        begin
            start_time_next  = now_ms;
            start_count_next = count;
        end
        else if (closed)
        begin
            res.delta        = delta;
            res.hit          = delta >= {16'd0, threshold};
            res.first        = res.hit && !alert_reg;
            alert_next       = alert_reg || res.hit;
            start_time_next  = now_ms;
            start_count_next = count;
        end
        res.alert = alert_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg  <= '0;
            start_count_reg <= '0;
            alert_reg       <= 1'b0;
        end
        else if (ctl.step)
        begin
            start_time_reg  <= start_time_next;
            start_count_reg <= start_count_next;
            alert_reg       <= alert_next;
        end
    end

endmodule
